// ----- design/nfza_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the next-fit zone allocator.
// No dependencies; imported by nfza_ram users and the top level.
package nfza_pkg;

    localparam int ARENA_GRANULES     = 4096;
    localparam int HEADER_BYTES       = 32;
    localparam int TRAILER_BYTES      = 4;
    localparam int MIN_FRAGMENT_BYTES = 64;

    localparam int GW      = $clog2(ARENA_GRANULES);   // granule index width
    localparam int LW      = GW + 1;                   // block length width
    localparam int SW      = LW + 1;                   // index + length sums
    localparam int OWNW    = 8;
    localparam int REQW    = 16;
    localparam int OFFW    = 15;
    localparam int REQ_SUM_W = REQW + 1;
    localparam int NEEDW   = REQ_SUM_W - 3;

    localparam logic [SW-1:0] ARENA_END = SW'(ARENA_GRANULES);
    localparam logic [REQ_SUM_W-1:0] OVERHEAD_RND =
        REQ_SUM_W'(HEADER_BYTES + TRAILER_BYTES + 7);
    localparam logic [OFFW-1:0] HDR_OFF = OFFW'(HEADER_BYTES);
    localparam logic [OFFW:0] ARENA_BYTES = (OFFW + 1)'(ARENA_GRANULES * 8);
    localparam logic [REQW-1:0] MIN_FRAG = REQW'(MIN_FRAGMENT_BYTES);
    localparam logic [REQW-1:0] HT_BYTES = REQW'(HEADER_BYTES + TRAILER_BYTES);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_REALLOC = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_NULL      = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_NOT_START = 3'd4;
    localparam logic [2:0] ST_FREED     = 3'd5;
    localparam logic [2:0] ST_ZERO_TAG  = 3'd6;

    // one block descriptor, kept at the block's first granule
    typedef struct packed {
        logic            mark;
        logic [LW-1:0]   len;
        logic [OWNW-1:0] owner;
    } t_blk;

    localparam int BLKW = $bits(t_blk);

    typedef struct packed {
        logic [REQW-1:0] used;
        logic [REQW-1:0] copy;
        logic [REQW-1:0] bbytes;
        logic [OFFW-1:0] roff;
        logic [2:0]      status;
    } t_result;

endpackage

// ----- design/nfza_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nfza_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/next_fit_zone_allocator.sv -----
`timescale 1ns / 1ps
// Next-fit zone allocator with free-neighbor coalescing; top level.
// Depends on nfza_pkg and two nfza_ram instances (descriptors, back links).
//
// One item is processed at a time. Block descriptors live in a 4096-entry
// RAM, back links in a second RAM; both have a registered read port.
// Allocate walks the blocks from the rover and writes the granted block and,
// on a split, the remaining fragment; free locates the block and merges it
// with a free preceding block (skipped at granule zero) and a free next
// block (skipped at the arena end); reallocate is a free followed by an
// allocate. Clear, and the pass after reset, sweep the descriptor RAM one
// entry per cycle, during which no item is accepted. A result waiting on
// the output does not block the next item.
module next_fit_zone_allocator
    import nfza_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // request_bytes, owner_tag, data_offset, pad
    input  logic [1:0]  i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata    // status, result_offset, block_bytes,
                                     // copy_bytes, used_bytes, pad
);
    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DISP  = 13'b0000000000100,
        S_LOC   = 13'b0000000001000,
        S_RPREV = 13'b0000000010000,
        S_NRD   = 13'b0000000100000,
        S_NCHK  = 13'b0000001000000,
        S_RFIN  = 13'b0000010000000,
        S_WRD   = 13'b0000100000000,
        S_WALK  = 13'b0001000000000,
        S_GW1   = 13'b0010000000000,
        S_GW2   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [REQW-1:0]  r_req, n_req;
    logic [OWNW-1:0]  r_tag, n_tag;
    logic [OFFW-1:0]  r_off, n_off;
    logic [GW-1:0]    r_g, n_g, r_first, n_first, r_prev, n_prev, r_nb, n_nb;
    logic [GW-1:0]    r_rover, n_rover, r_clr_cnt, n_clr_cnt;
    logic [LW-1:0]    r_len, n_len, r_extra, n_extra, r_steps, n_steps;
    logic [NEEDW-1:0] r_need, n_need;
    logic             r_split, n_split, r_had, n_had, r_emit, n_emit;
    logic [REQW-1:0]  r_used, n_used, r_copy, n_copy, r_bbytes, n_bbytes;
    logic [REQW-1:0]  r_old_user, n_old_user;
    logic [OFFW-1:0]  r_roff, n_roff;
    logic [2:0]       r_status, n_status;
    logic [OWNW-1:0]  r_gtag, n_gtag;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    // RAM ports
    logic          a_we, p_we;
    logic [GW-1:0] a_waddr, a_raddr, p_waddr, p_raddr;
    t_blk          a_wdata, a_rdata;
    logic [GW-1:0] p_wdata, p_rdata;

    nfza_ram #(.WIDTH(BLKW), .DEPTH(ARENA_GRANULES)) u_blk_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    nfza_ram #(.WIDTH(GW), .DEPTH(ARENA_GRANULES)) u_link_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    logic s_accept;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out};

    // combinational helpers
    logic [REQ_SUM_W-1:0] req_sum;
    logic [OFFW-1:0]      hb;
    logic [SW-1:0]        sum_a, sum_b;
    logic [LW-1:0]        extra_c, newlen;
    logic [GW-1:0]        frag;
    logic [SW-1:0]        after_g;

    always_comb begin
        req_sum = REQ_SUM_W'(r_req) + OVERHEAD_RND;
        hb      = r_off - HDR_OFF;
        extra_c = a_rdata.len - r_need[LW-1:0];
        newlen  = r_split ? r_need[LW-1:0] : r_len;
        frag    = r_g + r_need[GW-1:0];
        after_g = SW'(r_g) + SW'(r_len);
        sum_a   = '0;
        sum_b   = '0;

        n_state = r_state;   n_op = r_op;       n_req = r_req;   n_tag = r_tag;
        n_off = r_off;       n_g = r_g;         n_first = r_first;
        n_prev = r_prev;     n_nb = r_nb;       n_rover = r_rover;
        n_clr_cnt = r_clr_cnt; n_len = r_len;   n_extra = r_extra;
        n_steps = r_steps;   n_need = r_need;   n_split = r_split;
        n_had = r_had;       n_emit = r_emit;   n_used = r_used;
        n_copy = r_copy;     n_bbytes = r_bbytes; n_old_user = r_old_user;
        n_roff = r_roff;     n_status = r_status; n_gtag = r_gtag;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out = r_out;

        a_we = 1'b0; a_waddr = r_g; a_wdata = '0; a_raddr = r_g;
        p_we = 1'b0; p_waddr = r_g; p_wdata = r_g; p_raddr = r_g;

        case (r_state)
            S_CLR: begin
                a_we    = 1'b1;
                a_waddr = r_clr_cnt;
                if (r_clr_cnt == '0) begin
                    a_wdata = '{mark: 1'b1, len: LW'(ARENA_GRANULES), owner: '0};
                end
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == GW'(ARENA_GRANULES - 1)) begin
                    n_rover   = '0;
                    n_used    = '0;
                    n_clr_cnt = '0;
                    n_state   = r_emit ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_op    = t_op'(i_s_tuser);
                    n_req   = i_s_tdata[15:0];
                    n_tag   = i_s_tdata[23:16];
                    n_off   = i_s_tdata[38:24];
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status = ST_OK;
                n_roff   = '0;
                n_bbytes = '0;
                n_copy   = '0;
                n_had    = 1'b0;
                n_need   = req_sum[REQ_SUM_W-1:3];
                case (r_op)
                    OP_CLEAR: begin
                        n_emit  = 1'b1;
                        n_state = S_CLR;
                    end
                    OP_ALLOC: begin
                        n_gtag = r_tag;
                        if (r_tag == '0) begin
                            n_status = ST_ZERO_TAG;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_WRD;
                        end
                    end
                    default: begin
                        n_gtag = OWNW'(1);
                        if (r_off == '0) begin
                            // null on reallocate is a plain allocate
                            n_status = (r_op == OP_FREE) ? ST_NULL : ST_OK;
                            n_state  = (r_op == OP_FREE) ? S_OUT : S_WRD;
                        end else if (r_off < HDR_OFF ||
                                     {1'b0, hb} >= ARENA_BYTES) begin
                            n_status = ST_OUTSIDE;
                            n_state  = S_OUT;
                        end else if (hb[2:0] != 3'b0) begin
                            n_status = ST_NOT_START;
                            n_state  = S_OUT;
                        end else begin
                            n_g     = hb[GW+2:3];
                            a_raddr = hb[GW+2:3];
                            p_raddr = hb[GW+2:3];
                            n_state = S_LOC;
                        end
                    end
                endcase
            end
            S_LOC: begin
                if (!a_rdata.mark) begin
                    n_status = ST_NOT_START;
                    n_state  = S_OUT;
                end else if (a_rdata.owner == '0) begin
                    n_status = ST_FREED;
                    n_state  = S_OUT;
                end else begin
                    n_len      = a_rdata.len;
                    n_used     = r_used - {a_rdata.len, 3'b0};
                    n_had      = (r_op == OP_REALLOC);
                    n_old_user = {a_rdata.len, 3'b0} - HT_BYTES;
                    n_prev     = p_rdata;
                    a_raddr    = p_rdata;
                    n_state    = (r_g != '0) ? S_RPREV : S_NRD;
                end
            end
            S_RPREV: begin
                // merge into the preceding block if it is free
                if (a_rdata.owner == '0) begin
                    a_we    = 1'b1;
                    a_waddr = r_g;
                    a_wdata = '{mark: 1'b0, len: r_len, owner: '0};
                    if (after_g < ARENA_END) begin
                        p_we    = 1'b1;
                        p_waddr = after_g[GW-1:0];
                        p_wdata = r_prev;
                    end
                    if (r_rover == r_g) n_rover = r_prev;
                    n_g   = r_prev;
                    n_len = a_rdata.len + r_len;
                end
                n_state = S_NRD;
            end
            S_NRD: begin
                if (after_g < ARENA_END) begin
                    a_raddr = after_g[GW-1:0];
                    n_nb    = after_g[GW-1:0];
                    n_state = S_NCHK;
                end else begin
                    n_state = S_RFIN;
                end
            end
            S_NCHK: begin
                if (a_rdata.owner == '0) begin
                    sum_a   = SW'(r_nb) + SW'(a_rdata.len);
                    a_we    = 1'b1;
                    a_waddr = r_nb;
                    a_wdata = '{mark: 1'b0, len: a_rdata.len, owner: '0};
                    if (sum_a < ARENA_END) begin
                        p_we    = 1'b1;
                        p_waddr = sum_a[GW-1:0];
                        p_wdata = r_g;
                    end
                    if (r_rover == r_nb) n_rover = r_g;
                    n_len = r_len + a_rdata.len;
                end
                n_state = S_RFIN;
            end
            S_RFIN: begin
                a_we    = 1'b1;
                a_waddr = r_g;
                a_wdata = '{mark: 1'b1, len: r_len, owner: '0};
                n_state = (r_op == OP_REALLOC) ? S_WRD : S_OUT;
            end
            S_WRD: begin
                a_raddr = r_rover;
                n_g     = r_rover;
                n_first = r_rover;
                n_steps = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                sum_a = SW'(r_g) + SW'(a_rdata.len);
                sum_b = SW'(r_steps) + 1'b1;
                if (a_rdata.owner == '0 && NEEDW'(a_rdata.len) >= r_need) begin
                    n_len   = a_rdata.len;
                    n_extra = extra_c;
                    n_split = REQW'({extra_c, 3'b0}) > MIN_FRAG;
                    n_state = S_GW1;
                end else if (a_rdata.len == '0) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_OUT;
                end else begin
                    if (sum_a >= ARENA_END) sum_a = '0;
                    if (sum_a[GW-1:0] != r_first && sum_b < ARENA_END) begin
                        a_raddr = sum_a[GW-1:0];
                        n_g     = sum_a[GW-1:0];
                        n_steps = sum_b[LW-1:0];
                    end else begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_OUT;
                    end
                end
            end
            S_GW1: begin
                sum_a   = SW'(r_g) + SW'(newlen);
                a_we    = 1'b1;
                a_waddr = r_g;
                a_wdata = '{mark: 1'b1, len: newlen, owner: r_gtag};
                if (r_split) begin
                    p_we    = 1'b1;
                    p_waddr = frag;
                    p_wdata = r_g;
                end
                n_rover  = (sum_a >= ARENA_END) ? '0 : sum_a[GW-1:0];
                n_used   = r_used + {newlen, 3'b0};
                n_roff   = OFFW'({r_g, 3'b0}) + HDR_OFF;
                n_bbytes = {newlen, 3'b0};
                if (r_had) n_copy = (r_old_user < r_req) ? r_old_user : r_req;
                n_state  = r_split ? S_GW2 : S_OUT;
            end
            S_GW2: begin
                a_we    = 1'b1;
                a_waddr = frag;
                a_wdata = '{mark: 1'b1, len: r_extra, owner: '0};
                if (after_g < ARENA_END) begin
                    p_we    = 1'b1;
                    p_waddr = after_g[GW-1:0];
                    p_wdata = frag;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out = '{used: r_used, copy: r_copy, bbytes: r_bbytes,
                              roff: r_roff, status: r_status};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rover     <= '0;
            r_used      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
            r_rover     <= n_rover;
            r_used      <= n_used;
        end
        r_op <= n_op;         r_req <= n_req;       r_tag <= n_tag;
        r_off <= n_off;       r_g <= n_g;           r_first <= n_first;
        r_prev <= n_prev;     r_nb <= n_nb;         r_len <= n_len;
        r_extra <= n_extra;   r_steps <= n_steps;   r_need <= n_need;
        r_split <= n_split;   r_had <= n_had;       r_copy <= n_copy;
        r_bbytes <= n_bbytes; r_old_user <= n_old_user;
        r_roff <= n_roff;     r_status <= n_status; r_gtag <= n_gtag;
        r_out <= n_out;
    end

    // an accepted item blocks the input until its result is built
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input accepted twice without a result");

    // a result is only ever loaded from the output state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) || $past(i_m_tready)) && r_out_valid
            |-> $past(r_state == S_OUT))
        else $error("result loaded outside output state");

    // the walk never visits more blocks than the arena holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> SW'(r_steps) < ARENA_END)
        else $error("walk step count overran");

    // a granted block is always written with a start mark and a tag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GW1 |-> a_we && a_wdata.mark && a_wdata.owner != '0)
        else $error("granted block written without mark or tag");

    // status codes stay in their defined range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status <= ST_ZERO_TAG)
        else $error("undefined status code");
endmodule
